/* hw/rtl/avs_pkg.sv */
// avs_pkg: payload types, controller/datapath interface structs, constants
// and range tables for the autoranging voltmeter scaler
// depends on nothing
package avs_pkg;

  // input item tags
  localparam logic [1:0] MODE_PROBE = 2'd0;
  localparam logic [1:0] MODE_VOLT  = 2'd1;
  localparam logic [1:0] MODE_GAP   = 2'd2;

  // range codes
  localparam logic [1:0] RANGE_1M   = 2'd0;
  localparam logic [1:0] RANGE_100K = 2'd1;
  localparam logic [1:0] RANGE_5K   = 2'd2;

  localparam int SampleW    = 10;
  localparam int SumW       = 14;
  localparam int ReadingW   = SumW - 2;
  localparam int MultW      = 8;
  localparam int SupplyW    = 16;
  localparam int VoltsW     = 29;
  localparam int VoltShift  = 7;
  localparam int SumCount   = 16;
  localparam int DivW       = 23;
  localparam int DivCntW    = 5;
  localparam int LimitW     = 11;

  localparam logic [DivW-1:0]    SupplyNum = 23'd4464085;
  localparam logic [SupplyW-1:0] SupplyMax = 16'hFFFF;

  typedef struct packed {
    logic [1:0]         mode;
    logic [SampleW-1:0] sample;
  } in_t;

  typedef struct packed {
    logic [1:0]         range_sel;
    logic [VoltsW-1:0]  volts_fx;
    logic [SupplyW-1:0] supply_fx;
    logic               done_res;
  } out_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // capture an accepted item
    logic simple;    // apply a simple item and write its result
    logic start;     // final bandgap sample: snapshot sums, start divide
    logic div_step;  // one quotient bit
    logic mul1;      // reading times range multiplier, saturate supply
    logic mul2;      // times supply, store new voltage
    logic emit;      // write the completed voltage result
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_final;  // held item is the 16th bandgap sample
    logic div_last;  // last quotient bit this cycle
  } sts_t;

  // lower limit per range, code 3 behaves as the 5k range
  function automatic logic [LimitW-1:0] lower_lim(input logic [1:0] r);
    logic [LimitW-1:0] v;
    case (r)
      RANGE_1M:   v = 11'd0;
      RANGE_100K: v = 11'd151;
      default:    v = 11'd49;
    endcase
    return v;
  endfunction

  function automatic logic [LimitW-1:0] upper_lim(input logic [1:0] r);
    logic [LimitW-1:0] v;
    case (r)
      RANGE_1M:   v = 11'd941;
      RANGE_100K: v = 11'd805;
      default:    v = 11'd1024;
    endcase
    return v;
  endfunction

  function automatic logic [MultW-1:0] range_mult(input logic [1:0] r);
    logic [MultW-1:0] v;
    case (r)
      RANGE_1M:   v = 8'd2;
      RANGE_100K: v = 8'd11;
      default:    v = 8'd201;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/avs_dp.sv */
// avs_dp: datapath of the voltmeter scaler: item register, sums and counts,
// range logic, serial restoring divider, two-step multiply, result register
// depends on avs_pkg
module avs_dp (
  input  logic          clk,
  input  logic          rst,
  input  avs_pkg::in_t  item,
  input  avs_pkg::cmd_t cmd,
  output avs_pkg::sts_t sts,
  output avs_pkg::out_t result
);
  import avs_pkg::*;

  in_t                 held;
  logic [1:0]          range_state;
  logic [SumW-1:0]     volt_sum;
  logic [SumW-1:0]     gap_sum;
  logic [4:0]          volt_count;
  logic [3:0]          gap_count;
  logic [VoltsW-1:0]   last_volts;
  logic [SupplyW-1:0]  last_supply;

  logic [SumW-1:0]     divisor;
  logic [SumW-1:0]     rem;
  logic [DivW-1:0]     quo;
  logic [DivCntW-1:0]  div_cnt;
  logic [ReadingW-1:0] reading;
  logic [MultW-1:0]    mult;
  logic [ReadingW+MultW-1:0] prod1;
  logic [SupplyW-1:0]  supply;
  out_t                res;

  logic [1:0]          range_next;
  logic [LimitW-1:0]   s_ext;
  logic [SumW-1:0]     gap_sum_add;
  logic [SumW:0]       trial;
  logic                trial_ge;
  logic [ReadingW+MultW+SupplyW-1:0] prod2;

  assign s_ext       = {1'b0, held.sample};
  assign gap_sum_add = gap_sum + {{(SumW-SampleW){1'b0}}, held.sample};

  // range step for a probe
  always_comb begin
    range_next = range_state;
    if (held.mode == MODE_PROBE) begin
      if (s_ext < lower_lim(range_state)) begin
        if (range_state == 2'd3) range_next = RANGE_5K;
        else if (range_state != RANGE_1M) range_next = range_state - 2'd1;
      end else if (s_ext > upper_lim(range_state)) begin
        if (range_state == RANGE_1M || range_state == RANGE_100K) begin
          range_next = range_state + 2'd1;
        end
      end
    end
  end

  // restoring divider trial subtract
  assign trial    = {rem, quo[DivW-1]};
  assign trial_ge = trial >= {1'b0, divisor};
  assign prod2    = prod1 * supply;

  assign sts.is_final = (held.mode == MODE_GAP) && (gap_count == 4'(SumCount - 1));
  assign sts.div_last = (div_cnt == '0);
  assign result       = res;

  // held item
  always_ff @(posedge clk) begin
    if (cmd.load) held <= item;
  end

  // accumulated state
  always_ff @(posedge clk) begin
    if (rst) begin
      range_state <= RANGE_1M;
      volt_sum    <= '0;
      gap_sum     <= '0;
      volt_count  <= '0;
      gap_count   <= '0;
      last_volts  <= '0;
      last_supply <= '0;
    end else if (cmd.simple) begin
      range_state <= range_next;
      if (held.mode == MODE_VOLT && volt_count < 5'(SumCount)) begin
        volt_sum   <= volt_sum + {{(SumW-SampleW){1'b0}}, held.sample};
        volt_count <= volt_count + 5'd1;
      end
      if (held.mode == MODE_GAP) begin
        gap_sum   <= gap_sum_add;
        gap_count <= gap_count + 4'd1;
      end
    end else if (cmd.start) begin
      volt_sum   <= '0;
      gap_sum    <= '0;
      volt_count <= '0;
      gap_count  <= '0;
    end else if (cmd.mul2) begin
      last_volts  <= prod2[VoltShift +: VoltsW];
      last_supply <= supply;
    end
  end

  // divide and multiply registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      divisor <= gap_sum_add;
      rem     <= '0;
      quo     <= SupplyNum;
      div_cnt <= DivCntW'(DivW - 1);
      reading <= volt_sum[SumW-1:2];
      mult    <= range_mult(range_state);
    end else if (cmd.div_step) begin
      rem     <= trial_ge ? SumW'(trial - {1'b0, divisor}) : trial[SumW-1:0];
      quo     <= {quo[DivW-2:0], trial_ge};
      div_cnt <= div_cnt - DivCntW'(1);
    end else if (cmd.mul1) begin
      prod1  <= reading * mult;
      // a zero divisor yields all ones, so it saturates here as well
      supply <= (quo[DivW-1:SupplyW] != '0) ? SupplyMax : quo[SupplyW-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.simple) begin
      res.range_sel <= range_next;
      res.volts_fx  <= last_volts;
      res.supply_fx <= last_supply;
      res.done_res  <= 1'b0;
    end else if (cmd.emit) begin
      res.range_sel <= range_state;
      res.volts_fx  <= last_volts;
      res.supply_fx <= last_supply;
      res.done_res  <= 1'b1;
    end
  end

endmodule

/* hw/rtl/avs_ctrl.sv */
// avs_ctrl: controller state machine of the voltmeter scaler, owns the
// input and output occupancy flags and sequences divide and multiply
// depends on avs_pkg
module avs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  output logic          result_valid,
  input  logic          result_stall,
  input  avs_pkg::sts_t sts,
  output avs_pkg::cmd_t cmd
);
  import avs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_MUL1 = 5'b00100,
    S_MUL2 = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   in_full, in_full_next;
  logic   out_valid, out_valid_next;
  logic   out_free;
  logic   pop;
  logic   accept;

  assign out_free     = !out_valid || !result_stall;
  assign pop          = cmd.simple || cmd.start;
  assign item_stall   = in_full && !pop;
  assign accept       = item_valid && !item_stall;
  assign result_valid = out_valid;

  // sequencing
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.load   = accept;
    case (state)
      S_IDLE: begin
        if (in_full) begin
          if (sts.is_final) begin
            cmd.start  = 1'b1;
            state_next = S_DIV;
          end else if (out_free) begin
            cmd.simple = 1'b1;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // occupancy of the item and result registers
  always_comb begin
    in_full_next = in_full;
    if (accept) in_full_next = 1'b1;
    else if (pop) in_full_next = 1'b0;
    out_valid_next = out_valid && result_stall;
    if (cmd.simple || cmd.emit) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      in_full   <= in_full_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTH
  // an item is consumed only from a full item register
  a_pop_full: assert property (@(posedge clk) disable iff (rst)
    pop |-> in_full) else $error("item consumed from empty register");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.simple || cmd.emit) |-> out_free) else $error("result overwritten");

  // a written result is offered on the next cycle
  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    (cmd.simple || cmd.emit) |=> result_valid) else $error("result not offered");

  // a started divide is running on the next cycle
  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (state == S_DIV)) else $error("divide did not start");
`endif

endmodule

/* hw/rtl/autoranging_voltmeter_scaler.sv */
// autoranging_voltmeter_scaler: top level, joins controller and datapath
// depends on avs_pkg, avs_ctrl, avs_dp
//
// Each transfer in is held in one item register and handled from there, so
// the next transfer can be taken while a result waits in the output
// register. Range probes, voltage samples, unused tags and the first fifteen
// bandgap samples are each handled in a single step that writes the result.
// The sixteenth bandgap sample runs a sequence: a step to snapshot the sums,
// the one-bit-per-cycle restoring divider that forms the supply value, two
// multiply steps and a step to write the result. Exactly one result transfer
// follows each input transfer, in order.
module autoranging_voltmeter_scaler (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_stall,
  input  avs_pkg::in_t item,
  output logic         result_valid,
  input  logic         result_stall,
  output avs_pkg::out_t result
);
  import avs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  avs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  avs_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .sts    (sts),
    .result (result)
  );

endmodule
